/* rtl/biquad_cascade_equalizer_unit_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the equalizer
// ----------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_EQUALIZER_UNIT_MACROS_SVH
`define BIQUAD_CASCADE_EQUALIZER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/bce_pkg.sv */
// ----------------------------------------------------------------------------
// bce_pkg
// types and constants of the biquad cascade equalizer
// ----------------------------------------------------------------------------
package bce_pkg;
    localparam int Bands     = 10;
    localparam int Channels  = 2;
    localparam int BandW     = $clog2(Bands);
    localparam int ChW       = (Channels > 1) ? $clog2(Channels) : 1;
    localparam int CoefDepth = Bands * 5;
    localparam int CoefAw    = $clog2(CoefDepth);
    localparam int DlyDepth  = Bands * Channels * 4;
    localparam int DlyAw     = $clog2(DlyDepth);
    localparam int CoefShift = 26;
    localparam logic [31:0] CoefOne = 32'h0400_0000;

    localparam logic [0:0] CfgEnable   = 1'b0;
    localparam logic [0:0] CfgBandMask = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_BAND, S_RD, S_MAC, S_SAT, S_WB, S_OUT
    } t_state;
endpackage

/* rtl/biquad_cascade_equalizer_unit.sv */
// ----------------------------------------------------------------------------
// biquad_cascade_equalizer_unit
// cascade of direct form 1 biquads with coefficients and delays in memories
// ----------------------------------------------------------------------------
// A sample word is taken in the idle state, passes over each skipped band and goes through
// each applied band as coefficient fetch, read set-up, five multiply-accumulates on one shared
// 32x32 multiplier, saturation and four delay write-backs through the single delay memory
// port; its result is then moved out. When disabled, a sample word goes straight out. A
// coefficient word is written as it is taken. After reset a clearing pass over all 80
// delay entries (coefficients written alongside) runs before the first input word is
// taken. Results sit in an output register, so the next word is taken while a result
// waits.
`include "biquad_cascade_equalizer_unit_macros.svh"
module biquad_cascade_equalizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic        i_channel,
    input  logic signed [23:0] i_sample,
    input  logic        i_end_of_block,
    input  logic [3:0]  i_band,
    input  logic [2:0]  i_coef_index,
    input  logic signed [31:0] i_coef_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [23:0] o_sample_out,
    output logic        o_channel_out,
    output logic        o_end_of_block_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    localparam int BW = bce_pkg::BandW;
    localparam int CA = bce_pkg::CoefAw;
    localparam int DA = bce_pkg::DlyAw;

    logic [31:0] coef_mem [bce_pkg::CoefDepth];
    logic [31:0] dly_mem  [bce_pkg::DlyDepth];

    bce_pkg::t_state r_state, n_state;
    logic        r_enable;
    logic [9:0]  r_mask;
    logic [DA-1:0] r_clr, n_clr;
    logic [2:0]  r_cmod, n_cmod;
    logic [BW-1:0] r_band, n_band;
    logic [2:0]  r_step, n_step;
    logic        r_ch;
    logic        r_eob;
    logic signed [31:0] r_x, n_x;
    logic signed [31:0] r_y, n_y;
    logic signed [31:0] r_d [4];
    logic signed [79:0] r_acc, n_acc;
    logic        r_ovalid, n_ovalid;
    logic signed [23:0] r_osample, n_osample;
    logic        r_och;
    logic        r_oeob;

    logic        coef_we, dly_we;
    logic [CA-1:0] coef_wa, coef_ra;
    logic [DA-1:0] dly_wa, dly_ra;
    logic [31:0] coef_wd, dly_wd;
    logic signed [31:0] coef_rd, dly_rd;
    logic        in_acc, out_free, band_on;
    logic signed [63:0] prod;
    logic signed [79:0] acc_sh;
    logic signed [31:0] op_b;
    logic [DA-1:0] dly_base;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == bce_pkg::S_IDLE);
    assign in_acc   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ovalid;
    assign o_sample_out = r_osample;
    assign o_channel_out = r_och;
    assign o_end_of_block_out = r_oeob;
    assign band_on = r_mask[r_band];
    assign dly_base = DA'((32'(r_band) * bce_pkg::Channels + 32'(r_ch)) * 4);

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            coef_mem[coef_wa] <= coef_wd;
        end
        coef_rd <= coef_mem[coef_ra];
    end

    // delay memory
    always_ff @(posedge i_clk) begin
        if (dly_we) begin
            dly_mem[dly_wa] <= dly_wd;
        end
        dly_rd <= dly_mem[dly_ra];
    end

    // operand of the current product: x, then the four delay taps
    always_comb begin
        case (r_step)
            3'd1:    op_b = r_x;
            3'd2:    op_b = dly_rd;
            3'd3:    op_b = dly_rd;
            3'd4:    op_b = -dly_rd;
            default: op_b = -dly_rd;
        endcase
    end
    // negation of -2^31 is handled by negating the product instead
    always_comb begin
        if (r_step >= 3'd4) begin
            prod = -(64'(coef_rd) * 64'(dly_rd));
        end else begin
            prod = 64'(coef_rd) * 64'(op_b);
        end
    end
    assign acc_sh = r_acc >>> bce_pkg::CoefShift;

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_cmod = r_cmod;
        n_band = r_band;
        n_step = r_step;
        n_x = r_x;
        n_y = r_y;
        n_acc = r_acc;
        n_ovalid = r_ovalid;
        n_osample = r_osample;
        coef_we = 1'b0;
        coef_wa = '0;
        coef_wd = '0;
        coef_ra = '0;
        dly_we = 1'b0;
        dly_wa = '0;
        dly_wd = '0;
        dly_ra = '0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            bce_pkg::S_CLEAR: begin
                dly_we = 1'b1;
                dly_wa = r_clr;
                if (32'(r_clr) < bce_pkg::CoefDepth) begin
                    coef_we = 1'b1;
                    coef_wa = CA'(r_clr);
                    coef_wd = (r_cmod == 3'd0) ? bce_pkg::CoefOne : '0;
                end
                // position within the five coefficients of a band
                n_cmod = (r_cmod == 3'd4) ? 3'd0 : r_cmod + 3'd1;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == bce_pkg::DlyDepth - 1) begin
                    n_state = bce_pkg::S_IDLE;
                end
            end
            bce_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_action) begin
                        if (32'(i_band) < bce_pkg::Bands && i_coef_index <= 3'd4) begin
                            coef_we = 1'b1;
                            coef_wa = CA'(32'(i_band) * 5 + 32'(i_coef_index));
                            coef_wd = i_coef_value;
                        end
                    end else begin
                        n_x = 32'(i_sample);
                        n_band = '0;
                        if (r_enable && 32'(i_channel) < bce_pkg::Channels) begin
                            n_state = bce_pkg::S_BAND;
                        end else begin
                            n_state = bce_pkg::S_OUT;
                        end
                    end
                end
            end
            bce_pkg::S_BAND: begin
                if (band_on) begin
                    coef_ra = CA'(32'(r_band) * 5);
                    n_step = 3'd0;
                    n_acc = '0;
                    n_state = bce_pkg::S_RD;
                end else if (32'(r_band) == bce_pkg::Bands - 1) begin
                    n_state = bce_pkg::S_OUT;
                end else begin
                    n_band = r_band + 1'b1;
                end
            end
            bce_pkg::S_RD: begin
                // read pipeline: step k sees coef k-1 and delay k-2
                coef_ra = CA'(32'(r_band) * 5);
                dly_ra = dly_base;
                n_step = 3'd1;
                n_state = bce_pkg::S_MAC;
            end
            bce_pkg::S_MAC: begin
                n_acc = r_acc + 80'(prod);
                if (r_step < 3'd5) begin
                    coef_ra = CA'(32'(r_band) * 5 + 32'(r_step));
                    dly_ra = dly_base + DA'(r_step - 3'd1);
                end
                n_step = r_step + 1'b1;
                if (r_step == 3'd5) begin
                    n_state = bce_pkg::S_SAT;
                end
            end
            bce_pkg::S_SAT: begin
                if (acc_sh > 80'sd2147483647) begin
                    n_y = 32'sh7fff_ffff;
                end else if (acc_sh < -80'sd2147483648) begin
                    n_y = 32'sh8000_0000;
                end else begin
                    n_y = acc_sh[31:0];
                end
                n_step = 3'd0;
                n_state = bce_pkg::S_WB;
            end
            bce_pkg::S_WB: begin
                dly_we = 1'b1;
                dly_wa = dly_base + DA'(r_step);
                case (r_step[1:0])
                    2'd0: dly_wd = r_x;
                    2'd1: dly_wd = r_d[0];
                    2'd2: dly_wd = r_y;
                    default: dly_wd = r_d[2];
                endcase
                n_step = r_step + 1'b1;
                if (r_step == 3'd3) begin
                    n_x = r_y;
                    if (32'(r_band) == bce_pkg::Bands - 1) begin
                        n_state = bce_pkg::S_OUT;
                    end else begin
                        n_band = r_band + 1'b1;
                        n_state = bce_pkg::S_BAND;
                    end
                end
            end
            bce_pkg::S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_x > 32'sd8388607) begin
                        n_osample = 24'sh7fffff;
                    end else if (r_x < -32'sd8388608) begin
                        n_osample = 24'sh800000;
                    end else begin
                        n_osample = r_x[23:0];
                    end
                    n_state = bce_pkg::S_IDLE;
                end
            end
            default: n_state = bce_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bce_pkg::S_CLEAR;
            r_clr <= '0;
            r_cmod <= '0;
            r_enable <= 1'b1;
            r_mask <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_cmod <= n_cmod;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    bce_pkg::CfgEnable:   r_enable <= i_cfg_data[0];
                    bce_pkg::CfgBandMask: r_mask <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_band <= n_band;
        r_step <= n_step;
        r_x <= n_x;
        r_y <= n_y;
        r_acc <= n_acc;
        r_osample <= n_osample;
        if (in_acc) begin
            r_ch <= i_channel;
            r_eob <= i_end_of_block;
        end
        if (r_state == bce_pkg::S_OUT && out_free) begin
            r_och <= r_ch;
            r_oeob <= r_eob;
        end
        // keep delay taps read during the mac steps for write-back
        if (r_state == bce_pkg::S_MAC && r_step >= 3'd2) begin
            r_d[2'(r_step - 3'd2)] <= dly_rd;
        end
    end

    `BCE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && !i_ready, r_ovalid)
    `BCE_ASSERT_IMP(a_no_take_busy, i_clk, i_rst_n, r_state != bce_pkg::S_IDLE, !o_ready)
    `BCE_ASSERT_IMP(a_one_mem_write, i_clk, i_rst_n, r_state == bce_pkg::S_WB,
        !coef_we)
    `BCE_ASSERT_NEXT(a_sat_to_wb, i_clk, i_rst_n, r_state == bce_pkg::S_SAT,
        r_state == bce_pkg::S_WB)
endmodule

/* tb/sv/tb_biquad_cascade_equalizer_unit.sv */
// ----------------------------------------------------------------------------
// tb_biquad_cascade_equalizer_unit
// self-checking bench: drives sample and coefficient words with random gaps,
// predicts each filtered sample bit-exactly and compares it with the output
// ----------------------------------------------------------------------------
module tb_biquad_cascade_equalizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ActSample = 1'b0;
    localparam logic ActCoef   = 1'b1;

    typedef struct packed {
        logic signed [23:0] smp;
        logic               ch;
        logic               eob;
    } t_result;

    // scoreboard: holds equalizer state and the queue of expected samples
    class eq_scoreboard;
        logic signed [31:0] coefs [bce_pkg::Bands*5];
        logic signed [31:0] dly [bce_pkg::Bands*bce_pkg::Channels*4];
        logic       en;
        logic [9:0] mask;
        t_result    pending [$];
        int         errors;

        function void init();
            foreach (coefs[i]) coefs[i] = (i % 5 == 0) ? bce_pkg::CoefOne : 32'sd0;
            foreach (dly[i]) dly[i] = 32'sd0;
            en = 1'b1;
            mask = '0;
            pending.delete();
            errors = 0;
        endfunction

        function logic signed [31:0] apply_band(int b, int ch, logic signed [31:0] x);
            logic signed [127:0] acc;
            logic signed [127:0] shifted;
            int base;
            base = (b * bce_pkg::Channels + ch) * 4;
            acc = 128'(coefs[b*5]) * 128'(x)
                + 128'(coefs[b*5+1]) * 128'(dly[base])
                + 128'(coefs[b*5+2]) * 128'(dly[base+1])
                - 128'(coefs[b*5+3]) * 128'(dly[base+2])
                - 128'(coefs[b*5+4]) * 128'(dly[base+3]);
            shifted = acc >>> bce_pkg::CoefShift;
            if (shifted > 128'sh7fffffff) shifted = 128'sh7fffffff;
            else if (shifted < -128'sh80000000) shifted = -128'sh80000000;
            dly[base+1] = dly[base];
            dly[base]   = x;
            dly[base+3] = dly[base+2];
            dly[base+2] = shifted[31:0];
            return shifted[31:0];
        endfunction

        function void note_word(logic act, logic ch, logic signed [23:0] smp, logic eob,
                                logic [3:0] band, logic [2:0] ci,
                                logic signed [31:0] cv);
            logic signed [31:0] v;
            t_result r;
            if (act == ActCoef) begin
                if (band < bce_pkg::Bands && ci <= 4) coefs[band*5 + ci] = cv;
                return;
            end
            v = 32'(smp);
            if (en && ch < bce_pkg::Channels) begin
                for (int b = 0; b < bce_pkg::Bands; b++)
                    if (mask[b]) v = apply_band(b, ch, v);
                if (v > 32'sh7fffff) v = 32'sh7fffff;
                else if (v < -32'sh800000) v = -32'sh800000;
            end
            r.smp = v[23:0];
            r.ch = ch;
            r.eob = eob;
            pending.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output word %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected smp=%0d ch=%0b eob=%0b",
                              " got smp=%0d ch=%0b eob=%0b"},
                             want.smp, want.ch, want.eob, got.smp, got.ch, got.eob);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0, i_action = 1'b0, i_channel = 1'b0, i_end_of_block = 1'b0;
    logic signed [23:0] i_sample = '0;
    logic [3:0] i_band = '0;
    logic [2:0] i_coef_index = '0;
    logic signed [31:0] i_coef_value = '0;
    logic i_ready = 1'b0, i_cfg_valid = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [9:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_channel_out, o_end_of_block_out, o_cfg_ready;
    logic signed [23:0] o_sample_out;

    eq_scoreboard eq_sb;
    int out_gap = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    biquad_cascade_equalizer_unit u_top (.*);

    task automatic send_word(logic act, logic ch, logic signed [23:0] smp, logic eob,
                             logic [3:0] band, logic [2:0] ci, logic signed [31:0] cv);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_channel <= ch;
        i_sample <= smp;
        i_end_of_block <= eob;
        i_band <= band;
        i_coef_index <= ci;
        i_coef_value <= cv;
        do @(posedge i_clk); while (!o_ready);
        eq_sb.note_word(act, ch, smp, eob, band, ci, cv);
    endtask

    task automatic send_sample(logic signed [23:0] smp);
        send_word(ActSample, 1'($urandom), smp, 1'($urandom), 4'($urandom), 3'($urandom),
                  $urandom);
    endtask

    task automatic send_coef(logic [3:0] band, logic [2:0] ci, logic signed [31:0] cv);
        send_word(ActCoef, 1'($urandom), 24'($urandom), 1'($urandom), band, ci, cv);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [9:0] data);
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (eq_sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        // coefficient words leave no result, so let the datapath settle
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == bce_pkg::CfgEnable) eq_sb.en = data[0];
        else eq_sb.mask = data;
    endtask

    // stable, modest coefficients keep outputs off the rails most of the time
    task automatic load_band(logic [3:0] band);
        send_coef(band, 0, $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        send_coef(band, 1, $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        send_coef(band, 2, $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        send_coef(band, 3, $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        send_coef(band, 4, $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endtask

    // output side: after each taken word, i_ready stays low while out_gap counts down from a random start
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                eq_sb.check_word('{o_sample_out, o_channel_out, o_end_of_block_out});
                out_gap = $urandom_range(0, 3);
            end
            if (out_gap > 0) begin
                i_ready <= 1'b0;
                out_gap--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        eq_sb = new();
        eq_sb.init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: passthrough extremes, then extreme coefficients
        send_sample(24'sh7fffff);
        send_sample(-24'sh800000);
        send_sample(24'sd0);
        write_reg(bce_pkg::CfgBandMask, 10'h3ff);
        send_sample(24'sh7fffff);
        send_sample(-24'sh800000);
        send_coef(0, 0, 32'sh7fffffff);
        send_coef(1, 0, -32'sh80000000);
        send_coef(10, 0, 32'sd5);
        send_coef(15, 2, 32'sd5);
        send_coef(2, 5, 32'sd5);
        send_coef(2, 7, 32'sd5);
        send_sample(24'sh7fffff);
        send_sample(-24'sh800000);
        send_sample(24'sh123456);
        write_reg(bce_pkg::CfgEnable, 1'b0);
        send_sample(24'sh7fffff);
        send_sample(-24'sd1);
        write_reg(bce_pkg::CfgEnable, 1'b1);
        write_reg(bce_pkg::CfgBandMask, 10'h000);
        send_sample(24'sh400000);
        for (int b = 0; b < 16; b++) load_band(4'(b));
        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(bce_pkg::CfgBandMask,
                      (ph == 0) ? 10'h3ff : (ph == 1) ? 10'h001 : 10'($urandom));
            write_reg(bce_pkg::CfgEnable, (ph == 5) ? 1'b0 : 1'b1);
            for (int n = 0; n < 170; n++) begin
                if ($urandom_range(0, 19) == 0)
                    send_coef(4'($urandom), 3'($urandom),
                              ($urandom_range(0, 9) == 0) ? $urandom
                              : $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
                else if ($urandom_range(0, 29) == 0)
                    send_sample(($urandom_range(0, 1) == 0) ? 24'sh7fffff : -24'sh800000);
                else
                    send_sample(24'($urandom));
            end
            if (ph == 3) for (int b = 0; b < bce_pkg::Bands; b++) load_band(4'(b));
        end
        i_valid <= 1'b0;
        for (int w = 0; w < 200000 && eq_sb.pending.size() != 0; w++) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (eq_sb.pending.size() == 0 && eq_sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
